// ----- rtl/qfr_pkg.sv -----
// Shared widths, pipeline stage types and step functions for the matrix to quaternion
// converter. Depends on nothing; every other rtl file imports it.
`timescale 1ns / 1ps
package qfr_pkg;
  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int NUM_W     = DW + 1;
  localparam int S_W       = ((FRAC_BITS > DW) ? FRAC_BITS : DW) + 2;
  localparam int SQ_W      = ((S_W + FRAC_BITS + 3) / 4) * 4;
  localparam int RT_W      = SQ_W / 2;
  localparam int SQ_ST     = RT_W / 2;
  localparam int N_W       = NUM_W + FRAC_BITS + 1;
  localparam int Q_W       = DW;
  localparam int DV_ST     = Q_W / 2;
  localparam int CMP_W     = N_W + RT_W + 2;
  localparam int LAT       = SQ_ST + DV_ST + 3;

  localparam logic [1:0] PIV_TRACE = 2'd0;
  localparam logic [1:0] PIV_X     = 2'd1;
  localparam logic [1:0] PIV_Y     = 2'd2;
  localparam logic [1:0] PIV_Z     = 2'd3;

  typedef struct packed {
    logic [SQ_W-1:0] op;
    logic [RT_W+1:0] rem;
    logic [RT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [N_W-1:0] p;
    logic [Q_W-1:0] q;
    logic [RT_W:0]  den;
  } dv_t;

  typedef struct packed {
    logic [1:0]              pivot;
    logic signed [NUM_W-1:0] num_a;
    logic signed [NUM_W-1:0] num_b;
    logic signed [NUM_W-1:0] num_c;
  } side_t;

  typedef struct packed {
    logic [1:0]      pivot;
    logic            degen;
    logic [RT_W-1:0] half;
    logic [2:0]      neg;
    logic [2:0]      ovf;
  } tail_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic sq_t sq_step(input sq_t a);
    logic [RT_W+3:0] trial;
    logic [RT_W+3:0] test;
    sq_t r;
    trial  = {a.rem, a.op[SQ_W-1 -: 2]};
    test   = {2'b00, a.root, 2'b01};
    r.op   = {a.op[SQ_W-3:0], 2'b00};
    if (trial >= test) begin
      r.rem  = (RT_W+2)'(trial - test);
      r.root = {a.root[RT_W-2:0], 1'b1};
    end else begin
      r.rem  = (RT_W+2)'(trial);
      r.root = {a.root[RT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of the restoring divider at bit position b.
  function automatic dv_t dv_step(input dv_t a, input int b);
    logic [CMP_W-1:0] sh;
    dv_t r;
    r  = a;
    sh = CMP_W'(a.den) << b;
    if (CMP_W'(a.p) >= sh) begin
      r.p    = N_W'(CMP_W'(a.p) - sh);
      r.q[b] = 1'b1;
    end
    return r;
  endfunction
endpackage

// ----- rtl/qfr_front.sv -----
// Input stage: trace test, pivot choice, radicand and off-diagonal numerators.
// Depends on qfr_pkg.
`timescale 1ns / 1ps
module qfr_front (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [qfr_pkg::DW-1:0]    r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic [qfr_pkg::S_W-1:0]          s,
  output qfr_pkg::side_t                   side
);
  import qfr_pkg::*;

  logic signed [S_W:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [S_W:0] one, trace, s_raw;
  logic [S_W-1:0]      s_next;
  side_t               side_next;

  assign one = (S_W+1)'(1) <<< FRAC_BITS;
  assign e00 = (S_W+1)'(r00);
  assign e01 = (S_W+1)'(r01);
  assign e02 = (S_W+1)'(r02);
  assign e10 = (S_W+1)'(r10);
  assign e11 = (S_W+1)'(r11);
  assign e12 = (S_W+1)'(r12);
  assign e20 = (S_W+1)'(r20);
  assign e21 = (S_W+1)'(r21);
  assign e22 = (S_W+1)'(r22);
  assign trace = e00 + e11 + e22;

  always_comb begin
    side_next.pivot = PIV_TRACE;
    side_next.num_a = NUM_W'(e21 - e12);
    side_next.num_b = NUM_W'(e02 - e20);
    side_next.num_c = NUM_W'(e10 - e01);
    s_raw = trace + one;
    if (trace <= 0) begin
      // Ties keep the lower axis.
      if (e22 > e11 && e22 > e00) begin
        side_next.pivot = PIV_Z;
        s_raw = e22 - e00 - e11 + one;
        side_next.num_a = NUM_W'(e10 - e01);
        side_next.num_b = NUM_W'(e02 + e20);
        side_next.num_c = NUM_W'(e12 + e21);
      end else if (e11 > e00) begin
        side_next.pivot = PIV_Y;
        s_raw = e11 - e22 - e00 + one;
        side_next.num_a = NUM_W'(e02 - e20);
        side_next.num_b = NUM_W'(e21 + e12);
        side_next.num_c = NUM_W'(e01 + e10);
      end else begin
        side_next.pivot = PIV_X;
        s_raw = e00 - e11 - e22 + one;
        side_next.num_a = NUM_W'(e21 - e12);
        side_next.num_b = NUM_W'(e10 + e01);
        side_next.num_c = NUM_W'(e20 + e02);
      end
    end
    s_next = (s_raw < 0) ? '0 : S_W'(s_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s    <= s_next;
      side <= side_next;
    end
  end
endmodule

// ----- rtl/qfr_sqrt.sv -----
// Pipelined restoring square root, two root bits per register stage.
// Depends on qfr_pkg.
`timescale 1ns / 1ps
module qfr_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qfr_pkg::S_W-1:0]      s,
  output logic [qfr_pkg::RT_W-1:0]     root
);
  import qfr_pkg::*;

  sq_t st [SQ_ST];
  sq_t first;

  always_comb begin
    first.op   = SQ_W'({s, {FRAC_BITS{1'b0}}});
    first.rem  = '0;
    first.root = '0;
  end

  for (genvar g = 0; g < SQ_ST; g++) begin : g_stage
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (en) st[g] <= sq_step(sq_step(first));
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (en) st[g] <= sq_step(sq_step(st[g-1]));
      end
    end
  end

  assign root = st[SQ_ST-1].root;
endmodule

// ----- rtl/qfr_div.sv -----
// Pipelined restoring divider for one rounded quotient, two quotient bits per stage.
// Depends on qfr_pkg.
`timescale 1ns / 1ps
module qfr_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qfr_pkg::N_W-1:0]    dividend,
  input  logic [qfr_pkg::RT_W:0]     den,
  output logic [qfr_pkg::Q_W-1:0]    quot
);
  import qfr_pkg::*;

  dv_t st [DV_ST];
  dv_t first;

  always_comb begin
    first.p   = dividend;
    first.q   = '0;
    first.den = den;
  end

  for (genvar g = 0; g < DV_ST; g++) begin : g_stage
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (en) st[g] <= dv_step(dv_step(first, Q_W-1), Q_W-2);
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (en) st[g] <= dv_step(dv_step(st[g-1], Q_W-1-2*g), Q_W-2-2*g);
      end
    end
  end

  assign quot = st[DV_ST-1].q;
endmodule

// ----- rtl/qfr_back.sv -----
// Output stage: sign, saturation, degenerate zeroing and placement by pivot.
// Depends on qfr_pkg.
`timescale 1ns / 1ps
module qfr_back (
  input  logic                           clk,
  input  logic                           en,
  input  qfr_pkg::tail_t                 tail,
  input  logic [qfr_pkg::Q_W-1:0]        qa, qb, qc,
  output logic signed [qfr_pkg::DW-1:0]  quat_w, quat_x, quat_y, quat_z,
  output logic [1:0]                     pivot_case,
  output logic                           degenerate
);
  import qfr_pkg::*;

  localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

  function automatic logic [DW-1:0] fin(input logic [Q_W-1:0] q, input logic neg,
                                        input logic ovf, input logic degen);
    logic [DW-1:0] r;
    if (degen) r = '0;
    else if (neg) r = (ovf || q > NEG_MAG) ? NEG_MAG : DW'(-q);
    else r = (ovf || q > POS_MAX) ? POS_MAX : q;
    return r;
  endfunction

  logic [DW-1:0] ha, va, vb, vc;
  logic [DW-1:0] w_next, x_next, y_next, z_next;

  always_comb begin
    ha = (tail.half > RT_W'(POS_MAX)) ? POS_MAX : DW'(tail.half);
    va = fin(qa, tail.neg[0], tail.ovf[0], tail.degen);
    vb = fin(qb, tail.neg[1], tail.ovf[1], tail.degen);
    vc = fin(qc, tail.neg[2], tail.ovf[2], tail.degen);
    case (tail.pivot)
      PIV_TRACE: begin w_next = ha; x_next = va; y_next = vb; z_next = vc; end
      PIV_X:     begin w_next = va; x_next = ha; y_next = vb; z_next = vc; end
      PIV_Y:     begin w_next = va; x_next = vc; y_next = ha; z_next = vb; end
      default:   begin w_next = va; x_next = vb; y_next = vc; z_next = ha; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_w     <= w_next;
      quat_x     <= x_next;
      quat_y     <= y_next;
      quat_z     <= z_next;
      pivot_case <= tail.pivot;
      degenerate <= tail.degen;
    end
  end
endmodule

// ----- rtl/quaternion_from_rotation_matrix.sv -----
// Rotation matrix to unit quaternion converter, top level.
// Depends on qfr_pkg, qfr_front, qfr_sqrt, qfr_div and qfr_back.
//
// Input channel: in_valid/in_ready with the nine Q2.14 matrix elements.
// Output channel: out_valid/out_ready with quat_w..quat_z, pivot_case, degenerate.
// Each transfer in yields exactly one transfer out, in order.
// With the default format the pipeline has one front
// stage, eight square root stages (two root bits each), one stage that forms
// the rounded dividends, eight divider stages (two quotient bits each, three
// dividers side by side) and the output register.
// Throughput is one matrix per cycle. The whole pipeline moves together;
// it holds while the output register is full and out_ready is low, and
// in_ready is low only then. Nothing is dropped or repeated during a stall.
// Reset clears all valid bits; the pipeline is empty the cycle after.
`timescale 1ns / 1ps
module quaternion_from_rotation_matrix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [qfr_pkg::DW-1:0]  r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [qfr_pkg::DW-1:0]  quat_w, quat_x, quat_y, quat_z,
  output logic [1:0]                     pivot_case,
  output logic                           degenerate
);
  import qfr_pkg::*;

  logic             en;
  logic [LAT-1:0]   vld;
  logic [S_W-1:0]   s;
  side_t            side0;
  side_t            side_d [SQ_ST];
  logic [RT_W-1:0]  root;
  tail_t            tail_mid;
  tail_t            tail_d [DV_ST];
  logic [N_W-1:0]   na, nb, nc;
  logic [RT_W:0]    den;
  logic [Q_W-1:0]   qa, qb, qc;

  assign en        = out_ready || !vld[LAT-1];
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  qfr_front u_front (
    .clk, .en, .r00, .r01, .r02, .r10, .r11, .r12, .r20, .r21, .r22,
    .s, .side(side0)
  );

  qfr_sqrt u_sqrt (.clk, .en, .s, .root);

  for (genvar g = 0; g < SQ_ST; g++) begin : g_side
    if (g == 0) begin : g_head
      always_ff @(posedge clk) if (en) side_d[g] <= side0;
    end else begin : g_body
      always_ff @(posedge clk) if (en) side_d[g] <= side_d[g-1];
    end
  end

  // Rounded division: (|d| << F) + root over 2*root, with the quotient
  // overflow checked up front so the dividers need only Q_W bits.
  function automatic logic [N_W-1:0] mag_of(input logic signed [NUM_W-1:0] d);
    logic [NUM_W-1:0] m;
    m = d[NUM_W-1] ? NUM_W'(-d) : NUM_W'(d);
    return N_W'(m);
  endfunction

  logic [N_W-1:0]  na_next, nb_next, nc_next;
  logic [RT_W:0]   den_next;
  tail_t           tail_next;
  side_t           sl;

  always_comb begin
    sl        = side_d[SQ_ST-1];
    den_next  = {root, 1'b0};
    na_next   = (mag_of(sl.num_a) << FRAC_BITS) + N_W'(root);
    nb_next   = (mag_of(sl.num_b) << FRAC_BITS) + N_W'(root);
    nc_next   = (mag_of(sl.num_c) << FRAC_BITS) + N_W'(root);
    tail_next.pivot  = sl.pivot;
    tail_next.degen  = (root == '0);
    tail_next.half   = RT_W'(({1'b0, root} + (RT_W+1)'(1)) >> 1);
    tail_next.neg    = {sl.num_c[NUM_W-1], sl.num_b[NUM_W-1], sl.num_a[NUM_W-1]};
    tail_next.ovf[0] = CMP_W'(na_next) >= (CMP_W'(den_next) << Q_W);
    tail_next.ovf[1] = CMP_W'(nb_next) >= (CMP_W'(den_next) << Q_W);
    tail_next.ovf[2] = CMP_W'(nc_next) >= (CMP_W'(den_next) << Q_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na       <= na_next;
      nb       <= nb_next;
      nc       <= nc_next;
      den      <= den_next;
      tail_mid <= tail_next;
    end
  end

  qfr_div u_div_a (.clk, .en, .dividend(na), .den, .quot(qa));
  qfr_div u_div_b (.clk, .en, .dividend(nb), .den, .quot(qb));
  qfr_div u_div_c (.clk, .en, .dividend(nc), .den, .quot(qc));

  for (genvar g = 0; g < DV_ST; g++) begin : g_tail
    if (g == 0) begin : g_head
      always_ff @(posedge clk) if (en) tail_d[g] <= tail_mid;
    end else begin : g_body
      always_ff @(posedge clk) if (en) tail_d[g] <= tail_d[g-1];
    end
  end

  qfr_back u_back (
    .clk, .en, .tail(tail_d[DV_ST-1]), .qa, .qb, .qc,
    .quat_w, .quat_x, .quat_y, .quat_z, .pivot_case, .degenerate
  );
endmodule

// ----- rtl/qfr_checker.sv -----
// Port-level checks for the quaternion converter, bound to the top level.
// Depends on qfr_pkg and quaternion_from_rotation_matrix.
`timescale 1ns / 1ps
module qfr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [qfr_pkg::DW-1:0]  quat_w, quat_x, quat_y, quat_z,
  input logic [1:0]                     pivot_case,
  input logic                           degenerate
);
  import qfr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x))
    else $error("stalled result changed");

  a_trace_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && pivot_case == PIV_TRACE |-> !degenerate)
    else $error("degenerate flagged in the trace branch");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
    else $error("degenerate result has nonzero components");
endmodule

bind quaternion_from_rotation_matrix qfr_checker u_qfr_checker (
  .clk, .rst, .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z,
  .pivot_case, .degenerate
);
